// ===== src/pea_pkg.sv =====
// Shared types, constants and tables for the polarization edge angle pixel block.
package pea_pkg;

	// Configuration register indexes
	localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [12:0] FRAME_WIDTH_RST  = 13'd1280;
	localparam logic [12:0] FRAME_HEIGHT_RST = 13'd800;

	// CORDIC
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int CORDIC_LAT   = 1 + CORDIC_STEPS;

	// Q16 and Q15 angle constants
	localparam logic signed [19:0] PI_Q16      = 20'sd205887;
	localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [19:0] HALF_PI_Q15 = 20'sd51472;

	// Degree conversion: deg = floor(floor(N / 2^16) / 20000),
	// N = 2 * |e| * 572958 + 655360000; the division by 20000 uses a reciprocal
	localparam logic [20:0] DEG_NUM2    = 21'd1145916;
	localparam logic [29:0] DEG_DEN     = 30'd655360000;
	localparam logic [21:0] DEG_RECIP   = 22'd3435974;
	localparam int          DEG_RSHIFT  = 36;

	// Degree of polarization: square root and divider steps
	localparam int SQ_STEPS  = 27;
	localparam int DIV_STEPS = 16;
	localparam int DOP_LAT   = 2 + SQ_STEPS + DIV_STEPS;

	localparam int EDGE_LAT  = 4;
	localparam int ALIGN_LAT = DOP_LAT - CORDIC_LAT - EDGE_LAT;
	localparam int PIPE_LAT  = 1 + DOP_LAT;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [19:0] z;
		logic               sp;
		logic signed [19:0] spz;
	} cordic_st_t;

	typedef struct packed {
		logic [26:0] root;
		logic [29:0] rem;
		logic [21:0] m;
		logic [10:0] i;
		logic        ok;
	} sqrt_st_t;

	typedef struct packed {
		logic [27:0] rem;
		logic [11:0] d;
		logic [15:0] q;
		logic        ok;
	} div_st_t;

	typedef struct packed {
		logic [15:0] pa;
		logic [7:0]  deg;
	} angle_t;

	// round(atan(2^-i) * 2^16)
	function automatic logic signed [19:0] atan_q16(input int i);
		logic signed [19:0] r;
		unique case (i)
			0:       r = 20'sd51472;
			1:       r = 20'sd30386;
			2:       r = 20'sd16055;
			3:       r = 20'sd8150;
			4:       r = 20'sd4091;
			5:       r = 20'sd2047;
			6:       r = 20'sd1024;
			7:       r = 20'sd512;
			8:       r = 20'sd256;
			9:       r = 20'sd128;
			10:      r = 20'sd64;
			11:      r = 20'sd32;
			12:      r = 20'sd16;
			13:      r = 20'sd8;
			14:      r = 20'sd4;
			15:      r = 20'sd2;
			16:      r = 20'sd1;
			default: r = 20'sd0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/polarization_edge_angle_pixel.sv =====
// Polarization pixel block top level: Stokes sums, pipeline, output skid.
//
// Takes one pixel item per clock while s_tready is high, and gives one
// result item per pixel, in order. An accepted item loads the input stage
// at the accepting edge and then passes 45 stages of the degree of
// polarization path, then the output register. The latency is set by the
// degree-of-polarization path: a square stage and a range-check stage, 27
// stages of a bit-per-stage square root and 16 stages of a bit-per-stage
// divider. The two CORDIC units and the degree conversion run alongside and
// are delayed to match. With the output held, one further result is kept in
// a skid register before s_tready drops. Frame width and height must be
// written only while the block is idle; the block itself does not enforce it.
module polarization_edge_angle_pixel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// p45_ch0, p45_ch1, p45_ch2, p0_ch0, p0_ch1, p0_ch2,
	// p90_ch0, p90_ch1, p90_ch2, pixel_row, pixel_col
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// edge_angle_deg, pol_angle, pol_degree
	output logic [39:0] m_tdata,
	input  logic        cfg_wen,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	logic [12:0]        width_q, height_q;
	logic               en, accept;
	logic [9:0]         sum45, sum0, sum90;
	logic [10:0]        i_s1;
	logic signed [11:0] q_s1, u_s1;
	logic signed [12:0] rx_s1, cy_s1;
	logic [10:0]        isum;
	logic               vld_q [pea_pkg::PIPE_LAT];
	logic signed [19:0] a_pol, a_pos;
	logic [7:0]         deg;
	logic [15:0]        pa, dop;
	pea_pkg::angle_t    al_s [pea_pkg::ALIGN_LAT];
	logic [39:0]        pdata;
	logic               pvalid;
	logic [39:0]        out_q, skid_q;
	logic               ov_q, sv_q, take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= pea_pkg::FRAME_WIDTH_RST;
			height_q <= pea_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				pea_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data;
				pea_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	assign en       = !sv_q;
	assign s_tready = en;
	assign accept   = s_tvalid && en;

	// Stokes sums over the three channels
	always_comb begin
		sum45 = {2'b0, s_tdata[7:0]}   + {2'b0, s_tdata[15:8]}  + {2'b0, s_tdata[23:16]};
		sum0  = {2'b0, s_tdata[31:24]} + {2'b0, s_tdata[39:32]} + {2'b0, s_tdata[47:40]};
		sum90 = {2'b0, s_tdata[55:48]} + {2'b0, s_tdata[63:56]} + {2'b0, s_tdata[71:64]};
		isum  = {1'b0, sum0} + {1'b0, sum90};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			i_s1  <= isum;
			q_s1  <= $signed({2'b0, sum0}) - $signed({2'b0, sum90});
			u_s1  <= $signed({1'b0, sum45, 1'b0}) - $signed({1'b0, isum});
			rx_s1 <= $signed({1'b0, s_tdata[83:72]}) - $signed({1'b0, width_q[12:1]});
			cy_s1 <= $signed({1'b0, s_tdata[95:84]}) - $signed({1'b0, height_q[12:1]});
		end
	end

	// Valid bits travel with the items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < pea_pkg::PIPE_LAT; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= accept;
			for (int k = 1; k < pea_pkg::PIPE_LAT; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	pea_dop u_dop (
		.clk (clk),
		.en  (en),
		.i   (i_s1),
		.q   (q_s1),
		.u   (u_s1),
		.dop (dop)
	);

	pea_cordic u_cordic_pol (
		.clk (clk),
		.en  (en),
		.y   ({u_s1[11], u_s1}),
		.x   ({q_s1[11], q_s1}),
		.z   (a_pol)
	);

	pea_cordic u_cordic_pos (
		.clk (clk),
		.en  (en),
		.y   (cy_s1),
		.x   (rx_s1),
		.z   (a_pos)
	);

	pea_edge u_edge (
		.clk (clk),
		.en  (en),
		.a   (a_pol),
		.ooa (a_pos),
		.deg (deg),
		.pa  (pa)
	);

	// Delay angles to meet the degree of polarization
	always_ff @(posedge clk) begin
		if (en) begin
			al_s[0].pa  <= pa;
			al_s[0].deg <= deg;
			for (int k = 1; k < pea_pkg::ALIGN_LAT; k++) begin
				al_s[k] <= al_s[k-1];
			end
		end
	end

	assign pdata  = {dop, al_s[pea_pkg::ALIGN_LAT-1].pa, al_s[pea_pkg::ALIGN_LAT-1].deg};
	assign pvalid = vld_q[pea_pkg::PIPE_LAT-1];
	assign take   = ov_q && m_tready;

	// Output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (sv_q) begin
			if (take || !ov_q) begin
				ov_q <= 1'b1;
				sv_q <= 1'b0;
			end
		end else if (pvalid) begin
			if (!ov_q || take) begin
				ov_q <= 1'b1;
			end else begin
				sv_q <= 1'b1;
			end
		end else if (take) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sv_q) begin
			if (take || !ov_q) begin
				out_q <= skid_q;
			end
		end else if (pvalid) begin
			if (!ov_q || take) begin
				out_q <= pdata;
			end else begin
				skid_q <= pdata;
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = out_q;

endmodule

// ===== src/pea_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(y, x) in Q16 radians.
module pea_cordic (
	input  logic               clk,
	input  logic               en,
	input  logic signed [12:0] y,
	input  logic signed [12:0] x,
	output logic signed [19:0] z
);

	pea_pkg::cordic_st_t stg_s [0:pea_pkg::CORDIC_STEPS];
	pea_pkg::cordic_st_t prep;
	logic signed [31:0]  xs, ys;

	// Axis cases and pre-rotation into the right half plane
	always_comb begin
		xs = {{3{x[12]}}, x, 16'b0};
		ys = {{3{y[12]}}, y, 16'b0};
		prep.x   = xs;
		prep.y   = ys;
		prep.z   = '0;
		prep.sp  = (y == 13'sd0) || (x == 13'sd0);
		if (y == 13'sd0) begin
			prep.spz = (x < 13'sd0) ? pea_pkg::PI_Q16 : 20'sd0;
		end else begin
			prep.spz = (y > 13'sd0) ? pea_pkg::HALF_PI_Q16 : -pea_pkg::HALF_PI_Q16;
		end
		if (xs < 32'sd0) begin
			if (ys > 32'sd0) begin
				prep.x = ys;
				prep.y = -xs;
				prep.z = pea_pkg::HALF_PI_Q16;
			end else begin
				prep.x = -ys;
				prep.y = xs;
				prep.z = -pea_pkg::HALF_PI_Q16;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s[0] <= prep;
		end
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < pea_pkg::CORDIC_STEPS; i++) begin : g_step
		pea_pkg::cordic_st_t nxt;
		logic signed [31:0]  dx, dy;

		always_comb begin
			dx  = stg_s[i].y >>> i;
			dy  = stg_s[i].x >>> i;
			nxt = stg_s[i];
			if (stg_s[i].y >= 32'sd0) begin
				nxt.x = stg_s[i].x + dx;
				nxt.y = stg_s[i].y - dy;
				nxt.z = stg_s[i].z + pea_pkg::atan_q16(i);
			end else begin
				nxt.x = stg_s[i].x - dx;
				nxt.y = stg_s[i].y + dy;
				nxt.z = stg_s[i].z - pea_pkg::atan_q16(i);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[i+1] <= nxt;
			end
		end
	end

	assign z = stg_s[pea_pkg::CORDIC_STEPS].sp ? stg_s[pea_pkg::CORDIC_STEPS].spz
	                                           : stg_s[pea_pkg::CORDIC_STEPS].z;

endmodule

// ===== src/pea_dop.sv =====
// Degree of polarization: squares, bit-per-stage square root and divider.
module pea_dop (
	input  logic               clk,
	input  logic               en,
	input  logic [10:0]        i,
	input  logic signed [11:0] q,
	input  logic signed [11:0] u,
	output logic [15:0]        dop
);

	logic signed [23:0] qq, uu;
	logic [21:0]        ii;
	logic [19:0]        q2_s1;
	logic [21:0]        u2_s1, i2_s1;
	logic [10:0]        i_s1;
	logic [21:0]        m;

	pea_pkg::sqrt_st_t sq_s [0:pea_pkg::SQ_STEPS];
	pea_pkg::div_st_t  dv_s [pea_pkg::DIV_STEPS];
	pea_pkg::div_st_t  dv_in;

	// Squares
	always_comb begin
		qq = q * q;
		uu = u * u;
		ii = i * i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q2_s1 <= qq[19:0];
			u2_s1 <= uu[21:0];
			i2_s1 <= ii;
			i_s1  <= i;
		end
	end

	// Magnitude and range check
	assign m = {2'b0, q2_s1} + u2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0].root <= '0;
			sq_s[0].rem  <= '0;
			sq_s[0].m    <= m;
			sq_s[0].i    <= i_s1;
			sq_s[0].ok   <= (i_s1 != 11'd0) && (m <= i2_s1);
		end
	end

	// Square root of m * 2^32, one result bit per stage
	for (genvar k = 0; k < pea_pkg::SQ_STEPS; k++) begin : g_sqrt
		logic [1:0]        pair;
		logic [29:0]       nrem;
		logic [28:0]       trial;
		pea_pkg::sqrt_st_t nxt;

		if (k <= 10) begin : g_bits
			assign pair = sq_s[k].m[21-2*k -: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		always_comb begin
			nrem  = {sq_s[k].rem[27:0], pair};
			trial = {sq_s[k].root, 2'b01};
			nxt   = sq_s[k];
			if (nrem >= {1'b0, trial}) begin
				nxt.rem  = nrem - {1'b0, trial};
				nxt.root = {sq_s[k].root[25:0], 1'b1};
			end else begin
				nxt.rem  = nrem;
				nxt.root = {sq_s[k].root[25:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k+1] <= nxt;
			end
		end
	end

	// Rounded quotient (root + I) / (2 I)
	always_comb begin
		dv_in.rem = {1'b0, sq_s[pea_pkg::SQ_STEPS].root} + {17'b0, sq_s[pea_pkg::SQ_STEPS].i};
		dv_in.d   = {sq_s[pea_pkg::SQ_STEPS].i, 1'b0};
		dv_in.q   = '0;
		dv_in.ok  = sq_s[pea_pkg::SQ_STEPS].ok;
	end

	for (genvar j = 0; j < pea_pkg::DIV_STEPS; j++) begin : g_div
		localparam int B = pea_pkg::DIV_STEPS - 1 - j;
		pea_pkg::div_st_t cur, nxt;
		logic [27:0]      dsh;

		if (j == 0) begin : g_first
			assign cur = dv_in;
		end else begin : g_next
			assign cur = dv_s[j-1];
		end

		always_comb begin
			dsh = {16'b0, cur.d} << B;
			nxt = cur;
			if (cur.rem >= dsh) begin
				nxt.rem  = cur.rem - dsh;
				nxt.q[B] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j] <= nxt;
			end
		end
	end

	assign dop = dv_s[pea_pkg::DIV_STEPS-1].ok ? dv_s[pea_pkg::DIV_STEPS-1].q : 16'd0;

endmodule

// ===== src/pea_edge.sv =====
// Polarization angle scaling, edge angle wrap and conversion to degrees.
module pea_edge (
	input  logic               clk,
	input  logic               en,
	input  logic signed [19:0] a,
	input  logic signed [19:0] ooa,
	output logic [7:0]         deg,
	output logic [15:0]        pa
);

	logic signed [19:0] t;
	logic [15:0]        pa_s1, pa_s2, pa_s3, pa_s4;
	logic signed [19:0] ooa_s1;
	logic signed [20:0] aoe, aoe_w;
	logic [17:0]        mag_s2;
	logic               neg_s2, neg_s3;
	logic [38:0]        nprod;
	logic [21:0]        n_s3;
	logic [43:0]        rprod;
	logic [7:0]         qd;
	logic [7:0]         deg_s4;

	// Halve and round the angle, lift negatives, clamp
	always_comb begin
		t = (a + 20'sd2) >>> 2;
		if (a < 20'sd0) begin
			t = t + pea_pkg::HALF_PI_Q15;
		end
		if (t < 20'sd0) begin
			t = 20'sd0;
		end
		if (t > pea_pkg::HALF_PI_Q15) begin
			t = pea_pkg::HALF_PI_Q15;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1  <= t[15:0];
			ooa_s1 <= ooa;
		end
	end

	// Edge angle, wrapped once into +-pi/2
	always_comb begin
		aoe   = $signed({4'b0, pa_s1, 1'b0}) - {ooa_s1[19], ooa_s1};
		aoe_w = aoe;
		if (aoe > 21'(pea_pkg::HALF_PI_Q16)) begin
			aoe_w = aoe - 21'(pea_pkg::PI_Q16);
		end else if (aoe < -21'(pea_pkg::HALF_PI_Q16)) begin
			aoe_w = aoe + 21'(pea_pkg::PI_Q16);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2  <= pa_s1;
			neg_s2 <= aoe_w[20];
			mag_s2 <= aoe_w[20] ? 18'(-aoe_w) : aoe_w[17:0];
		end
	end

	// Scale to degrees, first part of the division
	assign nprod = 39'(mag_s2) * 39'(pea_pkg::DEG_NUM2) + 39'(pea_pkg::DEG_DEN);

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s3  <= pa_s2;
			neg_s3 <= neg_s2;
			n_s3   <= nprod[37:16];
		end
	end

	// Divide by 20000 through the reciprocal, apply sign
	always_comb begin
		rprod = 44'(n_s3) * 44'(pea_pkg::DEG_RECIP);
		qd    = rprod[pea_pkg::DEG_RSHIFT +: 8];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s4  <= pa_s3;
			deg_s4 <= neg_s3 ? 8'(-qd) : qd;
		end
	end

	assign deg = deg_s4;
	assign pa  = pa_s4;

endmodule

// ===== src/pea_checker.sv =====
// Port-level checker for the polarization edge angle pixel block, with bind.
module pea_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// A held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Input only backs up while a result is waiting
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	// Degree of polarization never above one
	a_dop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:24] <= 16'd32768)
		else $error("pol_degree above one");

	// Polarization angle within 0 .. pi/2
	a_aop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:8] <= 16'd51472)
		else $error("pol_angle above pi/2");

	// Wrapped edge angle within +-90 degrees
	a_edge: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[7:0]) >= -8'sd90) && ($signed(m_tdata[7:0]) <= 8'sd90))
		else $error("edge angle out of range");

endmodule

bind polarization_edge_angle_pixel pea_checker u_pea_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== verif/polarization_edge_angle_pixel_tb.sv =====
// Self-checking testbench for the polarization edge angle pixel block.
`timescale 1ns / 1ps

module polarization_edge_angle_pixel_tb;

	typedef struct packed {
		logic signed [7:0] deg;
		logic [15:0]       pa;
		logic [15:0]       dop;
	} pol_result_t;

	// Pixel predictor and queue of expected results
	class pol_scoreboard;
		pol_result_t pending[$];
		int          mismatches;
		int          orphans;
		logic [12:0] width;
		logic [12:0] height;

		function void set_reg(logic [0:0] idx, logic [12:0] val);
			if (idx == pea_pkg::REG_FRAME_WIDTH)
				width = val;
			else
				height = val;
		endfunction

		function longint fshift(longint v, int k);
			if (v >= 0)
				return v >>> k;
			return -((-v - 1) >>> k) - 1;
		endfunction

		function longint angle_q16(longint y, longint x);
			longint xs, ys, z, dx, dy, t;
			z = 0;
			if (y == 0)
				return (x < 0) ? longint'(pea_pkg::PI_Q16) : 0;
			if (x == 0)
				return (y > 0) ? longint'(pea_pkg::HALF_PI_Q16) :
					-longint'(pea_pkg::HALF_PI_Q16);
			xs = x * 65536;
			ys = y * 65536;
			if (xs < 0) begin
				if (ys > 0) begin
					t = xs; xs = ys; ys = -t; z = pea_pkg::HALF_PI_Q16;
				end else begin
					t = xs; xs = -ys; ys = t; z = -longint'(pea_pkg::HALF_PI_Q16);
				end
			end
			for (int i = 0; i < pea_pkg::CORDIC_STEPS; i++) begin
				dx = fshift(ys, i);
				dy = fshift(xs, i);
				if (ys >= 0) begin
					xs += dx; ys -= dy; z += pea_pkg::atan_q16(i);
				end else begin
					xs -= dx; ys += dy; z -= pea_pkg::atan_q16(i);
				end
			end
			return z;
		endfunction

		function longint root64(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		function void note_pixel(logic [95:0] px);
			longint si, sq, su, v45, v0, v90, row, col, m, a, pa, dop, ooa, e, mag, dg;
			pol_result_t r;
			si = 0; sq = 0; su = 0;
			for (int c = 0; c < 3; c++) begin
				v45 = px[8*c +: 8];
				v0  = px[24 + 8*c +: 8];
				v90 = px[48 + 8*c +: 8];
				si += v0 + v90;
				sq += v0 - v90;
				su += 2 * v45 - v0 - v90;
			end
			row = px[72 +: 12];
			col = px[84 +: 12];
			dop = 0;
			if (si != 0) begin
				m = sq * sq + su * su;
				if (m <= si * si)
					dop = (root64(longint'(m) << 32) + si) / (2 * si);
			end
			a = angle_q16(su, sq);
			pa = fshift(a + 2, 2);
			if (a < 0)
				pa += pea_pkg::HALF_PI_Q15;
			if (pa < 0)
				pa = 0;
			if (pa > pea_pkg::HALF_PI_Q15)
				pa = pea_pkg::HALF_PI_Q15;
			ooa = angle_q16(col - longint'(height >> 1), row - longint'(width >> 1));
			e = pa * 2 - ooa;
			if (e > pea_pkg::HALF_PI_Q16)
				e -= pea_pkg::PI_Q16;
			else if (e < -longint'(pea_pkg::HALF_PI_Q16))
				e += pea_pkg::PI_Q16;
			mag = ((e < 0) ? -e : e) * 572958;
			dg = (2 * mag + 655360000) / (2 * 64'd655360000);
			if (e < 0)
				dg = -dg;
			r.deg = dg[7:0];
			r.pa = pa[15:0];
			r.dop = dop[15:0];
			pending.push_back(r);
		endfunction

		function void check_result(logic [39:0] d);
			pol_result_t x;
			if (pending.size() == 0) begin
				orphans++;
				if (orphans + mismatches <= 10)
					$display("unexpected result %h", d);
				return;
			end
			x = pending.pop_front();
			if (d[7:0] !== x.deg || d[23:8] !== x.pa || d[39:24] !== x.dop) begin
				mismatches++;
				if (mismatches + orphans <= 10)
					$display("mismatch: deg exp %0d got %0d, pa exp %0d got %0d, dop exp %0d got %0d",
						x.deg, $signed(d[7:0]), x.pa, d[23:8], x.dop, d[39:24]);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// p45_ch0..2, p0_ch0..2, p90_ch0..2, pixel_row, pixel_col
	logic [95:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// edge_angle_deg, pol_angle, pol_degree
	logic [39:0] m_tdata;
	logic        cfg_wen;
	logic [0:0]  cfg_index;
	logic [12:0] cfg_data;
	logic        sink_on;

	pol_scoreboard sb;

	polarization_edge_angle_pixel uut (.*);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Result side: random stalls, checks every accepted item
	always @(posedge clk) begin
		if (arst_n && sink_on) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			m_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) == 0);
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [12:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic send_pixel(logic [95:0] px);
		int g;
		g = pick_gap();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_pixel(px);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (pea_pkg::PIPE_LAT + 10) @(posedge clk);
	endtask

	function automatic logic [95:0] make_pixel(int mode);
		logic [95:0] px;
		px = {$urandom, $urandom, $urandom};
		case (mode)
			// low intensities make zero sums likely
			1: for (int c = 0; c < 9; c++) px[8*c +: 8] = 8'($urandom_range(0, 3));
			// polarizer pair equal: q is zero, so the angle lies on an axis
			2: for (int c = 0; c < 3; c++) px[48 + 8*c +: 8] = px[24 + 8*c +: 8];
			// one camera dark
			3: px[24 +: 24] = 24'd0;
			default: ;
		endcase
		return px;
	endfunction

	// Directed pixels: extremes, axes, zero intensity, degree above one
	task automatic directed_part();
		send_pixel('0);
		send_pixel({24'hFFF_FFF, {9{8'hFF}}});
		send_pixel({12'd0, 12'd0, 24'h0, 24'hFFFFFF, 24'h0});
		send_pixel({12'd400, 12'd640, 24'hFFFFFF, 24'h0, 24'h0});
		send_pixel({12'd400, 12'd640, 24'h0, 24'hFFFFFF, 24'hFFFFFF});
		send_pixel({12'd400, 12'd640, 24'h0, 24'h0, 24'hFFFFFF});
		send_pixel({12'd0, 12'd4095, 24'h101010, 24'h101010, 24'h101010});
		send_pixel({12'd4095, 12'd0, 24'h102030, 24'h0, 24'hFF0000});
		send_pixel({12'd800, 12'd0, 24'h0, 24'h000001, 24'h0});
		send_pixel({12'd0, 12'd1280, 24'h000001, 24'h0, 24'h000001});
		for (int k = 0; k < 10; k++)
			send_pixel(make_pixel(k % 4));
	endtask

	task automatic random_part(int n);
		for (int k = 0; k < n; k++)
			send_pixel(make_pixel($urandom_range(0, 5)));
	endtask

	initial begin
		sb = new();
		sb.width = pea_pkg::FRAME_WIDTH_RST;
		sb.height = pea_pkg::FRAME_HEIGHT_RST;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = pea_pkg::REG_FRAME_WIDTH;
		cfg_data = '0;
		sink_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_part();
		random_part(400);
		drain();
		write_reg(pea_pkg::REG_FRAME_WIDTH, 13'd2);
		write_reg(pea_pkg::REG_FRAME_HEIGHT, 13'd4096);
		directed_part();
		random_part(300);
		drain();
		write_reg(pea_pkg::REG_FRAME_WIDTH, 13'h1FFF);
		write_reg(pea_pkg::REG_FRAME_HEIGHT, 13'd0);
		random_part(300);
		drain();
		write_reg(pea_pkg::REG_FRAME_WIDTH, 13'd1);
		write_reg(pea_pkg::REG_FRAME_HEIGHT, 13'd2);
		random_part(200);
		drain();
		write_reg(pea_pkg::REG_FRAME_WIDTH, 13'($urandom_range(2, 4096)));
		write_reg(pea_pkg::REG_FRAME_HEIGHT, 13'($urandom_range(2, 4096)));
		random_part(250);
		drain();
		if (sb.mismatches == 0 && sb.orphans == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
